FILE: design/hold_to_run_remote_with_timeout_defines.svh
// ---------------------------------------------------------------------------
// Hold-to-run remote: assertion macros
// Assertion helpers that disappear when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef HOLD_TO_RUN_REMOTE_WITH_TIMEOUT_DEFINES_SVH
`define HOLD_TO_RUN_REMOTE_WITH_TIMEOUT_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HRR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define HRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HRR_ASSERT_SAME(label, clk, rst, ante, cons)
`define HRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/hrr_pkg.sv
// ---------------------------------------------------------------------------
// Hold-to-run remote package
// Shared types, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package hrr_pkg;

   localparam logic [13:0] PRESS_MAX = 14'd9999;

   // Encodings of the idle seconds counter when it is not positive, and its first armed value.
   localparam logic [7:0] IDLE_OFF      = 8'h00;
   localparam logic [7:0] IDLE_WAIT_OFF = 8'hFF;
   localparam logic [7:0] IDLE_ARMING   = 8'hFE;
   localparam logic [7:0] IDLE_FIRST    = 8'h01;

   localparam logic [9:0]  DEBOUNCE_RESET = 10'd50;
   localparam logic [13:0] OFF_HOLD_RESET = 14'd1000;
   localparam logic [15:0] TPS_RESET      = 16'd1000;
   localparam logic [15:0] HALF_RESET     = 16'd500;
   localparam logic [6:0]  ON_SEC_RESET   = 7'd60;
   localparam logic [6:0]  WARN_SEC_RESET = 7'd50;

   localparam int unsigned CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_DEBOUNCE = 3'd0,
      REG_OFF_HOLD = 3'd1,
      REG_TPS      = 3'd2,
      REG_HALF     = 3'd3,
      REG_ON_SEC   = 3'd4,
      REG_WARN_SEC = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [9:0]  debounce_ticks;
      logic [13:0] off_hold_ticks;
      logic [15:0] ticks_per_second;
      logic [15:0] half_period_ticks;
      logic [6:0]  on_seconds;
      logic [6:0]  warn_seconds;
   } cfg_type;

   typedef struct packed {
      logic on_pressed;
      logic up_pressed;
      logic down_pressed;
   } buttons_type;

   typedef struct packed {
      logic up_drive;
      logic down_drive;
      logic drivers_enabled;
      logic led_lit;
   } outputs_type;

endpackage

`default_nettype wire

FILE: design/hold_to_run_remote_with_timeout.sv
// ---------------------------------------------------------------------------
// Hold-to-run remote with idle timeout
// Each request word is one millisecond tick carrying the on, up and down
// button states; each tick yields exactly one response word with the up and
// down motor drives, the driver enable and the status LED.
// Requests are taken into an input register; from there the tick is applied
// to the remote state, and the updated output latches are the response word
// itself. A tick therefore reaches the response channel through the input
// register and then the output latches, and one tick per cycle is sustained
// while the receiver keeps rsp_ready high.
// If the receiver stalls, the response word holds and one further tick may
// wait in the input register; req_ready falls only when both are occupied.
// Reset clears both stages and returns the remote to off with the LED lit
// for the boot flash. The timing settings sit in an APB-style register file
// (six 32-bit registers at byte addresses 0 to 20) and return to their
// defaults on reset; they are meant to be written while no tick is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "hold_to_run_remote_with_timeout_defines.svh"

module hold_to_run_remote_with_timeout (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_on_pressed,
   input  wire logic                           req_up_pressed,
   input  wire logic                           req_down_pressed,
   // Response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_up_drive,
   output logic                                rsp_down_drive,
   output logic                                rsp_drivers_enabled,
   output logic                                rsp_led_lit,
   // Configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [hrr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);
   import hrr_pkg::*;

   cfg_type     cfg;
   outputs_type latches;

   // Input register holding one accepted tick.
   logic        in_valid_ff, in_valid_in;
   buttons_type in_btn_ff;
   // Response word occupancy; the payload is the core's latch state.
   logic        rsp_valid_ff, rsp_valid_in;
   // The held tick is applied when the response slot is free or being freed.
   logic        step;
   logic        req_take;

   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_btn_ff.on_pressed   <= req_on_pressed;
         in_btn_ff.up_pressed   <= req_up_pressed;
         in_btn_ff.down_pressed <= req_down_pressed;
      end
   end

   hrr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   hrr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .btn     (in_btn_ff),
      .cfg     (cfg),
      .latches (latches)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_up_drive        = latches.up_drive;
   assign rsp_down_drive      = latches.down_drive;
   assign rsp_drivers_enabled = latches.drivers_enabled;
   assign rsp_led_lit         = latches.led_lit;

   // A motor is only ever driven while the drivers are enabled.
   `HRR_ASSERT_SAME(a_drive_needs_enable, clock, reset,
      latches.up_drive || latches.down_drive, latches.drivers_enabled)
   // Applying a tick always leaves a response word waiting.
   `HRR_ASSERT_NEXT(a_step_gives_word, clock, reset, step, rsp_valid_ff)
   // A waiting tick is neither lost nor altered while the response is stalled.
   `HRR_ASSERT_NEXT(a_held_tick_kept, clock, reset, in_valid_ff && !step,
      in_valid_ff && $stable(in_btn_ff))

endmodule

`default_nettype wire

FILE: design/hrr_csr.sv
// ---------------------------------------------------------------------------
// Hold-to-run remote configuration registers
// APB-style register file holding the six timing settings.
// ---------------------------------------------------------------------------
`default_nettype none

module hrr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hrr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output hrr_pkg::cfg_type                    cfg
);
   import hrr_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= DEBOUNCE_RESET;
         cfg_ff.off_hold_ticks    <= OFF_HOLD_RESET;
         cfg_ff.ticks_per_second  <= TPS_RESET;
         cfg_ff.half_period_ticks <= HALF_RESET;
         cfg_ff.on_seconds        <= ON_SEC_RESET;
         cfg_ff.warn_seconds      <= WARN_SEC_RESET;
      end else if (wr_en) begin
         case (index)
            REG_DEBOUNCE: cfg_ff.debounce_ticks    <= pwdata[9:0];
            REG_OFF_HOLD: cfg_ff.off_hold_ticks    <= pwdata[13:0];
            REG_TPS:      cfg_ff.ticks_per_second  <= pwdata[15:0];
            REG_HALF:     cfg_ff.half_period_ticks <= pwdata[15:0];
            REG_ON_SEC:   cfg_ff.on_seconds        <= pwdata[6:0];
            REG_WARN_SEC: cfg_ff.warn_seconds      <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DEBOUNCE: prdata = {22'd0, cfg_ff.debounce_ticks};
         REG_OFF_HOLD: prdata = {18'd0, cfg_ff.off_hold_ticks};
         REG_TPS:      prdata = {16'd0, cfg_ff.ticks_per_second};
         REG_HALF:     prdata = {16'd0, cfg_ff.half_period_ticks};
         REG_ON_SEC:   prdata = {25'd0, cfg_ff.on_seconds};
         REG_WARN_SEC: prdata = {25'd0, cfg_ff.warn_seconds};
         default:      prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/hrr_core.sv
// ---------------------------------------------------------------------------
// Hold-to-run remote core
// Remote state and the per-tick update; the latches form the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module hrr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire hrr_pkg::buttons_type btn,
   input  wire hrr_pkg::cfg_type     cfg,
   output hrr_pkg::outputs_type      latches
);
   import hrr_pkg::*;

   logic [7:0]  idle_ff, idle_in;
   logic [15:0] tick_ff, tick_in;
   logic [13:0] press_ff, press_in;
   logic        boot_ff, boot_in;
   outputs_type lat_ff, lat_in;

   logic [15:0] tick_next;
   logic [13:0] press_sat;
   logic        any_pressed;
   logic        deb_hit;
   logic [7:0]  idle_mid;
   logic [7:0]  idle_inc;
   logic        led_mid;

   assign latches = lat_ff;

   always_comb begin
      tick_next   = tick_ff + 16'd1;
      press_sat   = (press_ff < PRESS_MAX) ? press_ff + 14'd1 : press_ff;
      any_pressed = btn.up_pressed || btn.down_pressed || btn.on_pressed;
      deb_hit     = 1'b0;
      idle_mid    = idle_ff;
      idle_inc    = idle_ff;
      led_mid     = lat_ff.led_lit;

      idle_in  = idle_ff;
      tick_in  = tick_next;
      press_in = press_ff;
      boot_in  = boot_ff;
      lat_in   = lat_ff;

      if (idle_ff[7] || idle_ff == IDLE_OFF) begin
         // Off, or waiting for the on button to be released.
         lat_in.up_drive        = 1'b0;
         lat_in.down_drive      = 1'b0;
         lat_in.drivers_enabled = 1'b0;
         if (idle_ff[7] && btn.on_pressed) begin
            // Hold until release.
         end else if (idle_ff == IDLE_ARMING) begin
            idle_in                = IDLE_FIRST;
            lat_in.drivers_enabled = 1'b1;
            press_in               = '0;
         end else begin
            idle_in  = IDLE_OFF;
            press_in = (btn.on_pressed && press_ff < PRESS_MAX) ? press_ff + 14'd1 : '0;
            if (press_in > {4'd0, cfg.debounce_ticks}) begin
               boot_in        = 1'b0;
               idle_in        = IDLE_ARMING;
               lat_in.led_lit = 1'b1;
            end else if (boot_ff && tick_next == cfg.half_period_ticks) begin
               lat_in.led_lit = 1'b0;
               boot_in        = 1'b0;
            end else if (!boot_ff) begin
               lat_in.led_lit = 1'b0;
            end
         end
      end else begin
         // Armed.
         press_in = any_pressed ? press_sat : '0;
         deb_hit  = press_in > {4'd0, cfg.debounce_ticks};
         if (deb_hit) begin
            if (btn.up_pressed) begin
               lat_in.up_drive = 1'b1;
            end else if (btn.down_pressed) begin
               lat_in.down_drive = 1'b1;
            end
            idle_mid = IDLE_FIRST;
         end else begin
            lat_in.up_drive   = 1'b0;
            lat_in.down_drive = 1'b0;
         end

         if (deb_hit && btn.on_pressed && press_in > cfg.off_hold_ticks) begin
            // Long press of on: disarm and wait for release.
            idle_in        = IDLE_WAIT_OFF;
            lat_in.led_lit = 1'b0;
         end else begin
            if (tick_next >= cfg.half_period_ticks && idle_mid > {1'b0, cfg.warn_seconds}) begin
               led_mid = 1'b1;
            end
            idle_in        = idle_mid;
            lat_in.led_lit = led_mid;
            if (tick_next >= cfg.ticks_per_second) begin
               // Second boundary.
               tick_in  = '0;
               idle_inc = idle_mid + 8'd1;
               if (idle_inc >= {1'b0, cfg.on_seconds}) begin
                  idle_in        = IDLE_OFF;
                  lat_in.led_lit = 1'b0;
               end else if (idle_inc > {1'b0, cfg.warn_seconds}) begin
                  idle_in        = idle_inc;
                  lat_in.led_lit = 1'b0;
               end else begin
                  idle_in        = idle_inc;
                  lat_in.led_lit = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff                <= IDLE_OFF;
         tick_ff                <= '0;
         press_ff               <= '0;
         boot_ff                <= 1'b1;
         lat_ff.up_drive        <= 1'b0;
         lat_ff.down_drive      <= 1'b0;
         lat_ff.drivers_enabled <= 1'b0;
         lat_ff.led_lit         <= 1'b1;
      end else if (step) begin
         idle_ff  <= idle_in;
         tick_ff  <= tick_in;
         press_ff <= press_in;
         boot_ff  <= boot_in;
         lat_ff   <= lat_in;
      end
   end

endmodule

`default_nettype wire

FILE: dv/hold_to_run_remote_with_timeout_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hold-to-run remote testbench
// Drives button ticks through the request channel with bursty timing and a
// wandering response stall, mirrors the remote in a behavioural predictor,
// and compares every response word field by field. Timing registers move
// through small, extreme, out-of-range and reset settings between phases,
// and one long receiver hold-off fills the block and stalls its input.
// ---------------------------------------------------------------------------

module hold_to_run_remote_with_timeout_tb;
   import hrr_pkg::*;

   // One planned tick: the buttons, plus an optional hand-written result.
   typedef struct packed {
      buttons_type buttons;
      logic        typed;
      outputs_type want;
   } tick_type;

   localparam buttons_type BTN_NONE    = 3'b000;
   localparam buttons_type BTN_ON      = 3'b100;
   localparam buttons_type BTN_UP      = 3'b010;
   localparam buttons_type BTN_DOWN    = 3'b001;
   localparam buttons_type BTN_UP_DOWN = 3'b011;
   localparam buttons_type BTN_ALL     = 3'b111;

   localparam outputs_type OUT_LED_ONLY = 4'b0001;
   localparam outputs_type OUT_UNTYPED  = 4'b0000;
   localparam logic        TYPED        = 1'b1;
   localparam logic        PREDICTED    = 1'b0;

   // Idle seconds codes below zero, as the remote uses them.
   localparam int IDLE_WAIT_RELEASE = -1;
   localparam int IDLE_ARMING_CODE  = -2;

   // An index past the last register; a write there must change nothing.
   localparam logic [2:0] UNMAPPED_INDEX = 3'd6;

   // Responses at which the receiver starts its one long hold-off.
   localparam int HOLD_OFF_AFTER = 160;

   // The directed part runs with debounce 1, off hold 3, two ticks per
   // second, boot flash end at tick 3, three idle seconds and warning at 1.
   // It boots, arms, drives up, switches to down without a release, times
   // out, then arms again and is switched off by a long on press.
   localparam tick_type DIRECTED_TICKS [24] = '{
      {BTN_NONE,    TYPED,     OUT_LED_ONLY},  // fresh from reset: only the LED
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},   // boot flash ends here
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED},   // debounced: arming
      {BTN_ON,      TYPED,     OUT_LED_ONLY},  // waiting for on release
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},   // release enables the drivers
      {BTN_UP,      PREDICTED, OUT_UNTYPED},
      {BTN_UP,      PREDICTED, OUT_UNTYPED},
      {BTN_UP_DOWN, PREDICTED, OUT_UNTYPED},
      {BTN_DOWN,    PREDICTED, OUT_UNTYPED},   // up to down with no release
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_ALL,     PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},   // idle timeout by now
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_NONE,    PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED},
      {BTN_ON,      PREDICTED, OUT_UNTYPED}    // long press switches off
   };

   logic clock = 1'b0;
   logic reset;

   logic req_valid, req_ready;
   logic req_on_pressed, req_up_pressed, req_down_pressed;
   logic rsp_valid, rsp_ready;
   logic rsp_up_drive, rsp_down_drive, rsp_drivers_enabled, rsp_led_lit;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata, csr_prdata;

   // Predictor state: the timing settings and the remote itself.
   cfg_type     timing;
   int          idle_secs;
   logic [15:0] tick_cnt;
   logic [13:0] press_cnt;
   bit          boot_flash, up_on, down_on, drivers_on, led_on;

   tick_type    tick_plan[$];
   outputs_type pending_outputs[$];

   int ticks_sent, words_seen, mismatches, settings_written;

   hold_to_run_remote_with_timeout u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_on_pressed      (req_on_pressed),
      .req_up_pressed      (req_up_pressed),
      .req_down_pressed    (req_down_pressed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_up_drive        (rsp_up_drive),
      .rsp_down_drive      (rsp_down_drive),
      .rsp_drivers_enabled (rsp_drivers_enabled),
      .rsp_led_lit         (rsp_led_lit),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one millisecond tick to the predicted remote. The latches it
   // leaves behind are the response word for that tick.
   function automatic void advance_remote(buttons_type b);
      tick_cnt = tick_cnt + 16'd1;

      if (idle_secs <= 0) begin
         // Off, or waiting for the on button to be let go.
         up_on      = 1'b0;
         down_on    = 1'b0;
         drivers_on = 1'b0;
         if (idle_secs < 0 && b.on_pressed)
            return;
         if (idle_secs == IDLE_ARMING_CODE) begin
            idle_secs  = 1;
            drivers_on = 1'b1;
            press_cnt  = '0;
            return;
         end
         idle_secs = 0;
         if (b.on_pressed && press_cnt < PRESS_MAX)
            press_cnt = press_cnt + 14'd1;
         else
            press_cnt = '0;
         if (press_cnt > timing.debounce_ticks) begin
            boot_flash = 1'b0;
            idle_secs  = IDLE_ARMING_CODE;
            led_on     = 1'b1;
         end else if (boot_flash && tick_cnt == timing.half_period_ticks) begin
            led_on     = 1'b0;
            boot_flash = 1'b0;
         end else if (!boot_flash) begin
            led_on = 1'b0;
         end
         return;
      end

      // Armed: any button keeps the press count running.
      if (b.on_pressed || b.up_pressed || b.down_pressed) begin
         if (press_cnt < PRESS_MAX)
            press_cnt = press_cnt + 14'd1;
      end else begin
         press_cnt = '0;
      end

      if (press_cnt > timing.debounce_ticks) begin
         if (b.up_pressed)
            up_on = 1'b1;
         else if (b.down_pressed)
            down_on = 1'b1;
         idle_secs = 1;
         if (b.on_pressed && press_cnt > timing.off_hold_ticks) begin
            idle_secs = IDLE_WAIT_RELEASE;
            led_on    = 1'b0;
            return;
         end
      end else begin
         up_on   = 1'b0;
         down_on = 1'b0;
      end

      if (tick_cnt >= timing.half_period_ticks && idle_secs > timing.warn_seconds)
         led_on = 1'b1;

      if (tick_cnt < timing.ticks_per_second)
         return;
      tick_cnt  = '0;
      idle_secs = idle_secs + 1;
      if (idle_secs >= timing.on_seconds) begin
         idle_secs = 0;
         led_on    = 1'b0;
      end else if (idle_secs > timing.warn_seconds) begin
         led_on = 1'b0;
      end else begin
         led_on = 1'b1;
      end
   endfunction

   // Register write: setup cycle, then access cycle. The predictor's copy
   // takes the low bits of the field, and an unmapped index is ignored.
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_DEBOUNCE: timing.debounce_ticks    = value[9:0];
         REG_OFF_HOLD: timing.off_hold_ticks    = value[13:0];
         REG_TPS:      timing.ticks_per_second  = value[15:0];
         REG_HALF:     timing.half_period_ticks = value[15:0];
         REG_ON_SEC:   timing.on_seconds        = value[6:0];
         REG_WARN_SEC: timing.warn_seconds      = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes all six timing registers. The bits above each field carry
   // random junk, which the register must drop.
   task automatic set_timing(int unsigned debounce, int unsigned off_hold,
                             int unsigned per_second, int unsigned half_period,
                             int unsigned on_secs, int unsigned warn_secs);
      csr_write(REG_DEBOUNCE, ($urandom() << 10) | debounce);
      csr_write(REG_OFF_HOLD, ($urandom() << 14) | off_hold);
      csr_write(REG_TPS,      ($urandom() << 16) | per_second);
      csr_write(REG_HALF,     ($urandom() << 16) | half_period);
      csr_write(REG_ON_SEC,   ($urandom() << 7)  | on_secs);
      csr_write(REG_WARN_SEC, ($urandom() << 7)  | warn_secs);
      settings_written++;
   endtask

   task automatic plan_hold(buttons_type b, int unsigned count);
      repeat (count) tick_plan.push_back({b, PREDICTED, OUT_UNTYPED});
   endtask

   // Random button activity, built mostly from sequences a user would make
   // (arm, hold a motor button, long press to switch off, wait out the idle
   // timer) sized from the current settings, with some noise and some
   // presses that fall short of the debounce count.
   task automatic plan_session(int unsigned count);
      int unsigned goal, debounce_len, off_len, idle_len, hold_len;
      buttons_type b;
      goal         = tick_plan.size() + count;
      debounce_len = (timing.debounce_ticks > 40) ? 40 : timing.debounce_ticks;
      off_len      = (timing.off_hold_ticks > 60) ? 60 : timing.off_hold_ticks;
      idle_len     = (timing.ticks_per_second > 15) ? 30 :
                     2 * timing.ticks_per_second + 2;
      while (tick_plan.size() < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               hold_len = ($urandom_range(0, 4) == 0) ?
                          $urandom_range(1, debounce_len + 1) :
                          debounce_len + $urandom_range(1, 3);
               plan_hold(BTN_ON, hold_len);
               plan_hold(BTN_NONE, $urandom_range(1, 3));
            end
            3, 4: begin
               case ($urandom_range(0, 5))
                  0:       b = BTN_UP_DOWN;
                  1:       b = BTN_ALL;
                  2, 3:    b = BTN_UP;
                  default: b = BTN_DOWN;
               endcase
               plan_hold(b, $urandom_range(1, debounce_len + 6));
               plan_hold(BTN_NONE, $urandom_range(1, 3));
            end
            5: begin
               plan_hold(BTN_UP, debounce_len + 2);
               plan_hold(BTN_DOWN, $urandom_range(1, 5));
               plan_hold(BTN_NONE, 1);
            end
            6: begin
               plan_hold(BTN_ON, off_len + $urandom_range(1, 3));
               plan_hold(BTN_NONE, $urandom_range(1, 2));
            end
            7: plan_hold(BTN_NONE, $urandom_range(1, idle_len));
            default: begin
               repeat ($urandom_range(1, 8))
                  plan_hold(buttons_type'($urandom_range(0, 7)), 1);
            end
         endcase
      end
   endtask

   // Offers every planned tick in bursts of random length, with random gaps
   // and some bursts back to back. Valid stays up across a burst and only
   // the payload moves. Returns once every response word has come back and
   // the block has been given time to settle. Called at a falling edge.
   task automatic send_plan();
      int          burst_left, gap;
      tick_type    tick;
      outputs_type want;
      burst_left = 0;
      while (tick_plan.size() > 0) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 32);
         end
         tick = tick_plan[0];
         req_valid        <= 1'b1;
         req_on_pressed   <= tick.buttons.on_pressed;
         req_up_pressed   <= tick.buttons.up_pressed;
         req_down_pressed <= tick.buttons.down_pressed;
         do @(posedge clock); while (!req_ready);
         advance_remote(tick.buttons);
         want = {up_on, down_on, drivers_on, led_on};
         pending_outputs.push_back(tick.typed ? tick.want : want);
         void'(tick_plan.pop_front());
         ticks_sent++;
         burst_left--;
         @(negedge clock);
      end
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      // The settling wait keeps the next register write clear of the last response.
      repeat (3) @(negedge clock);
   endtask

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endtask

   // Response monitor: each accepted word is checked against the oldest
   // prediction still waiting.
   always @(posedge clock) begin : rsp_monitor
      outputs_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $error("response word with no tick waiting for it");
            mismatches++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("up_drive",        want.up_drive,        rsp_up_drive);
            check_field("down_drive",      want.down_drive,      rsp_down_drive);
            check_field("drivers_enabled", want.drivers_enabled, rsp_drivers_enabled);
            check_field("led_lit",         want.led_lit,         rsp_led_lit);
         end
         words_seen++;
      end
   end

   // Receiver: wanders between always ready, mostly ready and alternating.
   // Once, part-way through the run, it holds off for a long stretch while
   // the sender keeps offering, so both stages fill and req_ready falls.
   initial begin : rsp_stall
      int mode, span;
      bit held_off;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (!held_off && words_seen >= HOLD_OFF_AFTER) begin
               held_off = 1'b1;
               rsp_ready <= 1'b0;
               repeat ($urandom_range(60, 90)) @(negedge clock);
            end
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // Watchdog. The slowest correct run, with a gap before every tick and the
   // receiver at half rate throughout, is well under half of this.
   initial begin : watchdog
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_on_pressed   = 1'b0;
      req_up_pressed   = 1'b0;
      req_down_pressed = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;

      // Predictor starts where the block does after reset.
      timing     = {DEBOUNCE_RESET, OFF_HOLD_RESET, TPS_RESET, HALF_RESET,
                    ON_SEC_RESET, WARN_SEC_RESET};
      idle_secs  = 0;
      tick_cnt   = '0;
      press_cnt  = '0;
      boot_flash = 1'b1;
      up_on      = 1'b0;
      down_on    = 1'b0;
      drivers_on = 1'b0;
      led_on     = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through the life of the remote.
      set_timing(1, 3, 2, 3, 3, 1);
      foreach (DIRECTED_TICKS[i]) tick_plan.push_back(DIRECTED_TICKS[i]);
      send_plan();

      // Every register at its lowest legal value: everything happens fast.
      set_timing(1, 1, 2, 1, 2, 1);
      plan_session(100);
      send_plan();

      // Moderate settings; the long receiver hold-off lands in here.
      set_timing(4, 12, 9, 5, 6, 3);
      plan_session(100);
      send_plan();

      // A slower second, entered after a short released stretch, so that
      // new sessions start from off with the tick counter well advanced.
      set_timing(2, 8, 40, 20, 3, 1);
      plan_hold(BTN_NONE, 20);
      plan_session(50);
      send_plan();

      // Out-of-range settings: all zero, then a one-tick second with a
      // one-second timeout, a warning above the timeout and an off hold
      // the press count can never pass.
      set_timing(0, 0, 0, 0, 0, 0);
      plan_session(25);
      send_plan();
      set_timing(2, 16383, 1, 0, 1, 127);
      plan_session(25);
      send_plan();

      // Every register at its highest legal value.
      set_timing(1023, 9998, 65535, 65535, 127, 126);
      plan_session(30);
      send_plan();

      // A long timeout, then the timeout lowered under a session that may
      // still be armed, which must end it at the next second boundary. The
      // unmapped write in between must leave all settings alone.
      set_timing(2, 6, 3, 2, 20, 10);
      plan_session(90);
      send_plan();
      csr_write(UNMAPPED_INDEX, $urandom());
      set_timing(2, 6, 3, 2, 2, 1);
      plan_session(60);
      send_plan();

      // Back to the reset values.
      set_timing(DEBOUNCE_RESET, OFF_HOLD_RESET, TPS_RESET, HALF_RESET,
                 ON_SEC_RESET, WARN_SEC_RESET);
      plan_session(30);
      send_plan();

      $display("Covered %0d button ticks under %0d timing settings and a long hold-off;",
               ticks_sent, settings_written);
      $display("%0d response words checked, %0d mismatches.",
               words_seen, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
